FILE: rtl/core/ucf_pkg.sv
// Package for the UART command line framer: payload structs, event codes,
// character constants and sizing. Used by the top level and ucf_ctrl in rtl/core.
package ucf_pkg;

    // Line buffer sizing. The store holds one byte less than the buffer.
    localparam int BUF_BYTES = 128;
    localparam int LINE_CAP  = BUF_BYTES - 1;
    localparam int CNT_W     = $clog2(BUF_BYTES);
    localparam int ADDR_W    = $clog2(LINE_CAP);

    // Item function codes.
    localparam logic FUNC_RX   = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Event codes.
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_FRAME       = 3'd1;
    localparam logic [2:0] EV_USER        = 3'd2;
    localparam logic [2:0] EV_PASSWORD    = 3'd3;
    localparam logic [2:0] EV_LOGIN_RESET = 3'd4;
    localparam logic [2:0] EV_DISCARD     = 3'd5;

    // Login states.
    localparam logic [1:0] LOGIN_USER     = 2'd0;
    localparam logic [1:0] LOGIN_PASSWORD = 2'd1;
    localparam logic [1:0] LOGIN_DONE     = 2'd2;
    localparam logic [1:0] LOGIN_UNKNOWN  = 2'd3;

    // Characters.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_RESET = 8'hFF;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } in_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [6:0] payload_length;
        logic [7:0] read_data;
        logic [1:0] login_state;
    } out_t;

    // Result fields produced by the line controller.
    typedef struct packed {
        logic [2:0] event_res;
        logic [6:0] payload_length;
        logic [1:0] login_state;
    } status_t;

    // Write request into the line store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

endpackage

FILE: rtl/core/uart_command_line_framer_top.sv
// UART command line framer, top level.
// An accepted input beat's result beat is registered and offered next cycle.
// Throughput: one beat per cycle while m_ready is high; the result register
// and store read port load at the accepting edge; nothing else limits rate.
// Reset (aresetn, synchronous, active low): empty line, previous byte 0,
// login state unknown, no result pending. The line store is not cleared.
module uart_command_line_framer_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ucf_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output ucf_pkg::out_t m_payload
);
    import ucf_pkg::*;

    // An input beat is taken whenever the result register is empty or is
    // being emptied in the same cycle, so the block streams at full rate.
    // A waiting result holds off the next input beat only until the
    // receiver takes it.
    logic    accept;
    status_t status;
    wr_t     wr;

    logic              rd_req;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    logic    m_valid_reg;
    status_t status_reg;
    logic    rd_sel_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // The controller handles received bytes: counting, login prompts and
    // the terminator decisions. Read items leave its state unchanged.
    ucf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_payload),
        .status  (status),
        .wr      (wr)
    );

    // A read item reads the store at the accepting edge. The store's read
    // register loads only then, so it holds the byte while the result waits.
    // An index past the line capacity reads as zero.
    assign rd_req  = accept && (s_payload.func == FUNC_READ) &&
                     (32'(s_payload.read_index) < LINE_CAP);
    assign rd_addr = ADDR_W'(s_payload.read_index);

    ucf_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAP)
    ) u_line_store (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_req),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
            rd_sel_reg <= rd_req;
        end
    end

    assign m_valid                  = m_valid_reg;
    assign m_payload.event_res      = status_reg.event_res;
    assign m_payload.payload_length = status_reg.payload_length;
    assign m_payload.login_state    = status_reg.login_state;
    assign m_payload.read_data      = rd_sel_reg ? rd_data : 8'h00;

endmodule

FILE: rtl/core/ucf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ucf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ucf_ctrl.sv
// Line controller: byte count, first/last/previous byte and login state.
// Computes one item's result and the store write. Depends on ucf_pkg.
module ucf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  ucf_pkg::in_t    item,
    output ucf_pkg::status_t status,
    output ucf_pkg::wr_t    wr
);
    import ucf_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       prev_reg, prev_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       last_reg, last_next;
    logic [1:0]       mode_reg, mode_next;

    logic             is_rx;
    logic             is_term;
    logic             in_login;
    logic             prompt;
    logic [CNT_W-1:0] count_inc;
    logic [2:0]       ev;
    logic [6:0]       plen;

    always_comb begin
        is_rx      = (item.func == FUNC_RX);
        is_term    = (item.rx_byte == CH_CR) || (item.rx_byte == CH_LF);
        in_login   = (mode_reg == LOGIN_USER) || (mode_reg == LOGIN_PASSWORD);
        prompt     = in_login && (prev_reg == CH_COLON) && (item.rx_byte == CH_SPACE);
        count_inc  = count_reg + CNT_W'(1);

        count_next = count_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        last_next  = last_reg;
        mode_next  = mode_reg;
        ev         = EV_NONE;
        plen       = '0;
        wr.en      = 1'b0;
        wr.addr    = count_reg[ADDR_W-1:0];
        wr.data    = item.rx_byte;

        if (is_rx) begin
            prev_next = item.rx_byte;
            if (is_term) begin
                if (count_reg != '0) begin
                    count_next = '0;
                    if ((count_reg == CNT_W'(1)) && (first_reg == CH_RESET)) begin
                        mode_next = LOGIN_USER;
                        ev        = EV_LOGIN_RESET;
                    end else if (in_login) begin
                        ev = EV_DISCARD;
                    end else if ((count_reg >= CNT_W'(3)) && (prev_reg == CH_TILDE) &&
                                 (first_reg == CH_TILDE) && (last_reg == CH_TILDE)) begin
                        ev   = EV_FRAME;
                        plen = 7'(count_reg - CNT_W'(2));
                    end else begin
                        ev = EV_DISCARD;
                    end
                end
            end else if (count_reg < CNT_W'(LINE_CAP)) begin
                // The byte is stored; the first and last bytes are mirrored
                // in registers so the frame test needs no store read.
                wr.en      = 1'b1;
                last_next  = item.rx_byte;
                count_next = count_inc;
                if (count_reg == '0) begin
                    first_next = item.rx_byte;
                end
                if (prompt) begin
                    count_next = '0;
                    if (count_inc >= CNT_W'(3)) begin
                        ev        = (mode_reg == LOGIN_USER) ? EV_USER : EV_PASSWORD;
                        mode_next = mode_reg + 2'd1;
                    end else begin
                        ev = EV_DISCARD;
                    end
                end
            end
        end

        wr.en                 = wr.en && accept;
        status.event_res      = ev;
        status.payload_length = plen;
        status.login_state    = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            prev_reg  <= '0;
            mode_reg  <= LOGIN_UNKNOWN;
        end else if (accept) begin
            count_reg <= count_next;
            prev_reg  <= prev_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

endmodule

FILE: dv/tb_uart_command_line_framer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_command_line_framer_top: drives byte and read beats,
// predicts every result beat in-line and compares it field by field. Depends on ucf_pkg.
module tb_uart_command_line_framer_top;
    import ucf_pkg::*;

    // Clock, reset and the two channels. Every input starts at a known value.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    uart_command_line_framer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run-wide knobs and bookkeeping. The idle and stall rates are percentages
    // per cycle; hold_len, when set, forces the receiver off while it counts down.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int beats_sent     = 0;
    int beats_checked  = 0;
    int failures       = 0;
    int event_tally [0:7];

    // The framer as the testbench sees it: line store, fill level, the last
    // received byte and the login state, all reset the same way as the block.
    // line_written marks entries that hold a real byte, so reads never touch
    // an entry that the block has not written since power-up.
    logic [7:0]  line_mem     [0:LINE_CAP-1];
    bit          line_written [0:LINE_CAP-1];
    int unsigned line_len   = 0;
    logic [7:0]  last_rx    = 8'h00;
    logic [1:0]  login_mode = LOGIN_UNKNOWN;

    // Result beats predicted at input acceptance, oldest first.
    out_t pending_results [$];

    // Works out the result beat for one accepted input beat and moves the
    // framer state along with it.
    function automatic out_t framer_result_for(input in_t item);
        out_t res;
        logic prompt;
        res = '0;
        if (item.func == FUNC_READ) begin
            // Indexes past the line capacity read as zero.
            if (item.read_index < LINE_CAP)
                res.read_data = line_mem[item.read_index];
        end else begin
            if (item.rx_byte == CH_CR || item.rx_byte == CH_LF) begin
                // An empty line gives no event at all.
                if (line_len != 0) begin
                    if (line_len == 1 && line_mem[0] == CH_RESET) begin
                        login_mode    = LOGIN_USER;
                        res.event_res = EV_LOGIN_RESET;
                    end else if (login_mode == LOGIN_USER ||
                                 login_mode == LOGIN_PASSWORD) begin
                        res.event_res = EV_DISCARD;
                    end else if (line_len >= 3 && last_rx == CH_TILDE &&
                                 line_mem[0] == CH_TILDE &&
                                 line_mem[line_len - 1] == CH_TILDE) begin
                        // After an overflow the last received byte and the last
                        // stored byte can differ; both have to be a tilde.
                        res.event_res      = EV_FRAME;
                        res.payload_length = 7'(line_len - 2);
                    end else begin
                        res.event_res = EV_DISCARD;
                    end
                    line_len = 0;
                end
            end else if (line_len < LINE_CAP) begin
                // A full line drops the byte silently; otherwise it is stored and
                // colon-space may close a login prompt.
                prompt = (login_mode == LOGIN_USER || login_mode == LOGIN_PASSWORD) &&
                         last_rx == CH_COLON && item.rx_byte == CH_SPACE;
                line_mem[line_len]     = item.rx_byte;
                line_written[line_len] = 1'b1;
                line_len++;
                if (prompt) begin
                    if (line_len >= 3) begin
                        res.event_res = (login_mode == LOGIN_USER) ? EV_USER : EV_PASSWORD;
                        login_mode    = login_mode + 2'd1;
                    end else begin
                        res.event_res = EV_DISCARD;
                    end
                    line_len = 0;
                end
            end
            last_rx = item.rx_byte;
        end
        res.login_state = login_mode;
        return res;
    endfunction

    // Offers one input beat and holds it until the block takes it. The valid
    // line is only lowered inside an idle gap, so a back-to-back beat never
    // sees valid dropped and raised within one time step.
    task automatic send_beat(input in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(framer_result_for(item));
        beats_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        in_t item;
        item.func       = FUNC_RX;
        item.rx_byte    = b;
        item.read_index = 7'($urandom_range(127));
        send_beat(item);
    endtask

    // Reads one stored byte: a written entry, or an index past the capacity.
    task automatic send_read(input int idx);
        in_t item;
        item.func       = FUNC_READ;
        item.rx_byte    = 8'($urandom_range(255));
        item.read_index = 7'(idx);
        send_beat(item);
    endtask

    task automatic send_random_read();
        int idx;
        idx = $urandom_range(LINE_CAP);
        if (idx < LINE_CAP && !line_written[idx])
            idx = 0;
        send_read(idx);
    endtask

    task automatic send_terminator();
        send_rx($urandom_range(1) ? CH_CR : CH_LF);
    endtask

    // Sends n random bytes that are not line terminators.
    task automatic send_text(input int n);
        logic [7:0] b;
        repeat (n) begin
            do
                b = 8'($urandom_range(255));
            while (b == CH_CR || b == CH_LF);
            send_rx(b);
        end
    endtask

    // A login prompt: name bytes, then colon and space. With no name the
    // prompt is too short and the line is thrown away instead.
    task automatic send_prompt(input int name_len);
        send_text(name_len);
        send_rx(CH_COLON);
        send_rx(CH_SPACE);
    endtask

    task automatic send_login_reset();
        send_rx(CH_RESET);
        send_terminator();
    endtask

    // One line of random traffic. Half the lines are frames or login sequences
    // with random content; the rest are broken frames, reads, raw noise, empty
    // lines and lone login resets.
    task automatic send_random_line();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 35) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(130, 100) : $urandom_range(8);
            send_rx(CH_TILDE);
            send_text(n);
            send_rx(CH_TILDE);
            send_terminator();
        end else if (pick < 50) begin
            send_login_reset();
            send_prompt($urandom_range(6));
            if ($urandom_range(4) != 0) begin
                send_prompt($urandom_range(6));
            end else begin
                send_text($urandom_range(1, 4));
                send_terminator();
            end
        end else if (pick < 62) begin
            if ($urandom_range(1)) begin
                send_rx(CH_TILDE);
                send_text($urandom_range(1, 6));
            end else begin
                send_text($urandom_range(1, 6));
                send_rx(CH_TILDE);
            end
            send_terminator();
        end else if (pick < 78) begin
            repeat ($urandom_range(1, 4))
                send_random_read();
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 6))
                send_rx(8'($urandom_range(255)));
        end else if (pick < 94) begin
            repeat ($urandom_range(1, 2))
                send_terminator();
        end else begin
            send_login_reset();
        end
    endtask

    // Receiver side: a forced hold-off takes priority and is counted down here;
    // otherwise ready drops at random at the current stall rate.
    always @(posedge aclk) begin
        if (hold_len > 0) begin
            m_ready  <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic log_failure(input string what, input out_t want, input out_t got);
        failures++;
        if (failures <= 10)
            $display("%0t ns %s: expected ev %0d len %0d data %02h login %0d, got ev %0d len %0d data %02h login %0d",
                     $time, what, want.event_res, want.payload_length, want.read_data,
                     want.login_state, got.event_res, got.payload_length, got.read_data,
                     got.login_state);
    endtask

    // Result checker: every accepted result beat is matched against the oldest
    // prediction. Signals are sampled at the edge, before that edge's updates.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                log_failure("result beat with nothing expected", '0, m_payload);
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                event_tally[want.event_res]++;
                if (m_payload.event_res !== want.event_res ||
                    m_payload.payload_length !== want.payload_length ||
                    m_payload.read_data !== want.read_data ||
                    m_payload.login_state !== want.login_state)
                    log_failure("result mismatch", want, m_payload);
            end
        end
    end

    // Right after reset the login state is unknown, so frames are accepted
    // without logging in. Covers the empty line, a good frame, a frame that is
    // too short, reads at the lowest index and past the capacity.
    task automatic test_unknown_state_frames();
        send_terminator();
        send_rx(CH_TILDE);
        send_rx(8'h00);
        send_rx(CH_TILDE);
        send_rx(CH_LF);
        send_rx(CH_TILDE);
        send_rx(CH_TILDE);
        send_rx(CH_CR);
        send_read(0);
        send_read(127);
    endtask

    // Walks the login state machine: reset to waiting for the user, a prompt
    // that is too short, user and password prompts, a plain line thrown away
    // while a password is awaited, and a final login reset from logged in.
    task automatic test_login_flow();
        send_login_reset();
        send_prompt(0);
        send_prompt(1);
        send_rx(8'hFF);
        send_rx(8'h80);
        send_rx(CH_CR);
        send_prompt(1);
        send_login_reset();
    endtask

    // Fills the line to capacity so further bytes are dropped. The first two
    // lines fail because either the last received byte or the last stored
    // byte is not a tilde; the third is the longest possible frame.
    task automatic test_line_overflow();
        send_login_reset();
        send_prompt(2);
        send_prompt(2);
        send_rx(CH_TILDE);
        send_text(LINE_CAP - 2);
        send_rx(CH_TILDE);
        send_rx(CH_COLON);
        send_rx(CH_CR);
        send_rx(CH_TILDE);
        send_text(LINE_CAP - 2);
        send_rx(CH_COLON);
        send_rx(CH_TILDE);
        send_rx(CH_LF);
        send_rx(CH_TILDE);
        send_text(LINE_CAP - 2);
        send_rx(CH_TILDE);
        send_rx(CH_TILDE);
        send_rx(CH_CR);
    endtask

    // Random lines until beat_goal more beats have gone in, at the given
    // sender idle and receiver stall rates.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int beat_goal);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = beats_sent + beat_goal;
        while (beats_sent < stop_at)
            send_random_line();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats back to back, so the block fills and stops taking input.
    task automatic test_receiver_backpressure();
        hold_len = 300;
        test_random_traffic(0, 0, 40);
    endtask

    initial begin
        int drain_cycles;
        foreach (event_tally[i])
            event_tally[i] = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unknown_state_frames();
        test_login_flow();
        test_line_overflow();
        test_random_traffic(0, 0, 340);
        test_receiver_backpressure();
        test_random_traffic(66, 0, 340);
        test_random_traffic(0, 66, 340);
        test_random_traffic(36, 36, 340);

        // Stimulus done: let every predicted beat come back, then keep the clock
        // running afterwards so a stray extra result beat would still be seen.
        s_valid      <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d result beats never arrived", pending_results.size());
            failures += pending_results.size();
        end

        $display("Sent %0d input beats and checked %0d results, %0d failures.",
                 beats_sent, beats_checked, failures);
        $display("Frames %0d, user %0d, password %0d, login resets %0d, discards %0d.",
                 event_tally[EV_FRAME], event_tally[EV_USER], event_tally[EV_PASSWORD],
                 event_tally[EV_LOGIN_RESET], event_tally[EV_DISCARD]);
        if (failures == 0)
            $display("uart_command_line_framer_top regression: pass");
        else
            $display("uart_command_line_framer_top regression: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5000000;
        $display("uart_command_line_framer_top regression: fail");
        $finish;
    end

endmodule
